FILE: rtl/jesc_pkg.sv
// ---------------------------------------------------------------------------
// jesc_pkg
// Shared types and constants of the Julia escape-time pixel core: the item
// payloads, the fixed-point widths and the register map.
// ---------------------------------------------------------------------------
package jesc_pkg;

    // Number of z = z*z + c updates tried for each pixel.
    localparam int ITER_LIMIT = 64;

    // Fraction bits of the z and c components.
    localparam int FRAC_BITS = 14;

    // Width of a z component while it is in flight. The start value needs
    // 16 bits, and an update from |z| < 2 stays below 2^18 in magnitude.
    localparam int Z_W = 20;

    // Width of a product of two z components, and of a sum of two of them.
    localparam int PROD_W = 2 * Z_W;
    localparam int SUM_W  = PROD_W + 1;

    // Escape threshold: |z|^2 = 4 in the format of a product.
    localparam logic signed [SUM_W-1:0] ESC_LIMIT =
        SUM_W'(64'sd4 <<< (2 * FRAC_BITS));

    // Width of the update counter and of the configuration registers.
    localparam int CNT_W  = 7;
    localparam int CREG_W = 16;

    // APB register map.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_C_REAL = 1'b0;
    localparam logic [0:0] REG_C_IMAG = 1'b1;

    // Reset values of the Julia constant (0 + 1.0i).
    localparam logic signed [CREG_W-1:0] C_REAL_RESET = 16'sd0;
    localparam logic signed [CREG_W-1:0] C_IMAG_RESET = 16'sd16384;

    // One input item.
    typedef struct packed {
        logic [8:0] pixel_row;
        logic [8:0] pixel_col;
    } t_pixel_in;

    // One result item.
    typedef struct packed {
        logic [6:0] escape_count;
        logic [7:0] blue_byte;
        logic [7:0] green_byte;
        logic [7:0] red_byte;
    } t_pixel_out;

    // State of one pixel between iteration stages.
    typedef struct packed {
        logic signed [Z_W-1:0] re;
        logic signed [Z_W-1:0] im;
        logic [CNT_W-1:0]      count;
        logic                  done;
    } t_iter_data;

endpackage

FILE: rtl/jesc_iter.sv
// ---------------------------------------------------------------------------
// jesc_iter
// One z = z*z + c update in two register stages: the three products are
// registered first, then the escape test and the update are made.
// ---------------------------------------------------------------------------
module jesc_iter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  jesc_pkg::t_iter_data                   i_data,
    input  logic signed [jesc_pkg::CREG_W-1:0]     i_c_real,
    input  logic signed [jesc_pkg::CREG_W-1:0]     i_c_imag,
    output logic                                   o_valid,
    output jesc_pkg::t_iter_data                   o_data
);

    logic signed [jesc_pkg::Z_W-1:0]    w_re;
    logic signed [jesc_pkg::Z_W-1:0]    w_im;
    logic signed [jesc_pkg::PROD_W-1:0] n_rr;
    logic signed [jesc_pkg::PROD_W-1:0] n_ii;
    logic signed [jesc_pkg::PROD_W-1:0] n_ri;

    logic                               r_a_valid;
    jesc_pkg::t_iter_data               r_a_data;
    logic signed [jesc_pkg::PROD_W-1:0] r_rr;
    logic signed [jesc_pkg::PROD_W-1:0] r_ii;
    logic signed [jesc_pkg::PROD_W-1:0] r_ri;

    logic signed [jesc_pkg::SUM_W-1:0]  w_mag;
    logic signed [jesc_pkg::SUM_W-1:0]  w_diff;
    logic signed [jesc_pkg::Z_W-1:0]    w_c_re;
    logic signed [jesc_pkg::Z_W-1:0]    w_c_im;
    jesc_pkg::t_iter_data               n_b_data;

    logic                               r_b_valid;
    jesc_pkg::t_iter_data               r_b_data;

    // Squares and cross product of the current z.
    always_comb begin
        w_re = i_data.re;
        w_im = i_data.im;
        n_rr = w_re * w_re;
        n_ii = w_im * w_im;
        n_ri = w_re * w_im;
    end

    // Product stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    // Product stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_data <= i_data;
            r_rr     <= n_rr;
            r_ii     <= n_ii;
            r_ri     <= n_ri;
        end
    end

    // Escape test and update. A pixel that has escaped keeps its count and
    // passes through the remaining stages untouched.
    always_comb begin
        w_mag  = jesc_pkg::SUM_W'(r_rr) + jesc_pkg::SUM_W'(r_ii);
        w_diff = jesc_pkg::SUM_W'(r_rr) - jesc_pkg::SUM_W'(r_ii);
        w_c_re = jesc_pkg::Z_W'(i_c_real);
        w_c_im = jesc_pkg::Z_W'(i_c_imag);
        n_b_data = r_a_data;
        if (!r_a_data.done) begin
            if (w_mag >= jesc_pkg::ESC_LIMIT) begin
                n_b_data.done = 1'b1;
            end else begin
                // Selecting the bits above the fraction gives the floor of the Q.28 values.
                n_b_data.re = w_diff[jesc_pkg::FRAC_BITS +: jesc_pkg::Z_W] + w_c_re;
                n_b_data.im = r_ri[jesc_pkg::FRAC_BITS-1 +: jesc_pkg::Z_W] + w_c_im;
                n_b_data.count = r_a_data.count + jesc_pkg::CNT_W'(1);
            end
        end
    end

    // Update stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    // Update stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

FILE: rtl/jesc_colour.sv
// ---------------------------------------------------------------------------
// jesc_colour
// Output stage: turns the update count into the escape count and the three
// colour bytes and holds the result item until it is taken.
// ---------------------------------------------------------------------------
module jesc_colour (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  jesc_pkg::t_iter_data i_data,
    output logic                 o_valid,
    output jesc_pkg::t_pixel_out o_data
);

    logic [jesc_pkg::CNT_W-1:0] w_esc;
    jesc_pkg::t_pixel_out       n_data;
    logic                       r_valid;
    jesc_pkg::t_pixel_out       r_data;

    // Escape count is updates plus one; the bytes are its multiples.
    always_comb begin
        w_esc               = i_data.count + jesc_pkg::CNT_W'(1);
        n_data.escape_count = w_esc;
        n_data.blue_byte    = {w_esc, 1'b0};
        n_data.red_byte     = {w_esc[5:0], 2'b00};
        n_data.green_byte   = {w_esc, 1'b0} + {w_esc[5:0], 2'b00};
    end

    // Output register valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/julia_escape_time_pixel_core.sv
// ---------------------------------------------------------------------------
// julia_escape_time_pixel_core
// Julia set escape-time pixel core: maps a pixel position to a start value,
// runs up to 64 iterations of z = z*z + c and returns the escape count and
// three colour bytes.
// ---------------------------------------------------------------------------
// The core is a fully unrolled pipeline that accepts one item in every cycle
// while the output is empty or being taken. An item passes through the input
// stage, each of the 64 iteration stages (a product register, then an escape
// test and update register) and the output register. The whole pipeline
// advances together and holds when a result is waiting and the output is
// not ready, so while it holds no item is accepted. The Julia constant is
// set through the APB port (c_real at byte address 0, c_imag at 4, low 16
// bits of the data) and must be written only while no item is in flight.
module julia_escape_time_pixel_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input item channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  jesc_pkg::t_pixel_in              i_in_data,
    // Result item channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output jesc_pkg::t_pixel_out             o_out_data,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [jesc_pkg::PADDR_W-1:0]     paddr,
    input  logic [jesc_pkg::PDATA_W-1:0]     pwdata,
    output logic [jesc_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    logic                                  w_en;
    logic                                  w_wr;
    logic signed [jesc_pkg::CREG_W-1:0]    r_c_real;
    logic signed [jesc_pkg::CREG_W-1:0]    r_c_imag;

    jesc_pkg::t_iter_data                  n_in_data;
    logic                                  r_in_valid;
    jesc_pkg::t_iter_data                  r_in_data;

    logic                                  w_valid [0:jesc_pkg::ITER_LIMIT];
    jesc_pkg::t_iter_data                  w_data  [0:jesc_pkg::ITER_LIMIT];

    // The pipeline moves while the output register is empty or being read.
    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real <= jesc_pkg::C_REAL_RESET;
            r_c_imag <= jesc_pkg::C_IMAG_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                jesc_pkg::REG_C_REAL: r_c_real <= pwdata[jesc_pkg::CREG_W-1:0];
                jesc_pkg::REG_C_IMAG: r_c_imag <= pwdata[jesc_pkg::CREG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back, sign-extended to the bus width.
    always_comb begin
        case (paddr[2])
            jesc_pkg::REG_C_REAL: prdata = jesc_pkg::PDATA_W'(r_c_real);
            jesc_pkg::REG_C_IMAG: prdata = jesc_pkg::PDATA_W'(r_c_imag);
            default:              prdata = '0;
        endcase
    end

    // Start value: position * 128 - 2.0 in Q.14 for each component.
    always_comb begin
        n_in_data.re    = $signed({4'b0000, i_in_data.pixel_row, 7'b0000000})
                          - jesc_pkg::Z_W'(32768);
        n_in_data.im    = $signed({4'b0000, i_in_data.pixel_col, 7'b0000000})
                          - jesc_pkg::Z_W'(32768);
        n_in_data.count = '0;
        n_in_data.done  = 1'b0;
    end

    // Input stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_data <= n_in_data;
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_data[0]  = r_in_data;

    // Chain of iteration stages, one update each.
    for (genvar g = 0; g < jesc_pkg::ITER_LIMIT; g++) begin : g_iter
        jesc_iter u_iter (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_valid[g]),
            .i_data   (w_data[g]),
            .i_c_real (r_c_real),
            .i_c_imag (r_c_imag),
            .o_valid  (w_valid[g+1]),
            .o_data   (w_data[g+1])
        );
    end

    // Colour mapping and output register.
    jesc_colour u_colour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[jesc_pkg::ITER_LIMIT]),
        .i_data  (w_data[jesc_pkg::ITER_LIMIT]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Julia escape-time pixel core regression
// Streams pixel positions into the core under several Julia constants,
// including the extremes and values outside the stated range, and compares
// every result item against a fixed-point escape-time predictor. Both
// channels idle at random, the receiver twice holds off long enough to fill
// the pipeline, and the constant is only changed once the core has drained.
// ---------------------------------------------------------------------------
module tb_top;

    import jesc_pkg::*;

    localparam int FRAME_SIZE     = 512;
    localparam int N_PHASES       = 7;
    localparam int RAND_PER_PHASE = 228;
    localparam int DRAIN_CYCLES   = 140;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_LEN       = 500;
    localparam int HOLD_AT_A      = 60;
    localparam int HOLD_AT_B      = 700;
    localparam int MAX_REPORTS    = 10;

    localparam logic [PADDR_W-1:0] ADDR_C_REAL = PADDR_W'(4 * REG_C_REAL);
    localparam logic [PADDR_W-1:0] ADDR_C_IMAG = PADDR_W'(4 * REG_C_IMAG);

    // Holds the expected escape results in order and compares each result item.
    class escape_count_tracker;
        longint     c_re;
        longint     c_im;
        t_pixel_out expected_escapes[$];
        int         failures;

        function new();
            c_re     = 0;
            c_im     = 0;
            failures = 0;
        endfunction

        function void set_constant(logic [15:0] cr, logic [15:0] ci);
            c_re = longint'($signed(cr));
            c_im = longint'($signed(ci));
        endfunction

        // Escape-time iteration in Q.14, rounding toward minus infinity.
        function t_pixel_out predict_escape(t_pixel_in p);
            t_pixel_out  res;
            longint      re;
            longint      im;
            longint      rr;
            longint      ii;
            longint      ri;
            int unsigned updates;
            bit          escaped;
            re      = ((longint'(p.pixel_row) << 16) / FRAME_SIZE) - (longint'(2) << FRAC_BITS);
            im      = ((longint'(p.pixel_col) << 16) / FRAME_SIZE) - (longint'(2) << FRAC_BITS);
            updates = 0;
            escaped = 1'b0;
            while (!escaped && updates < ITER_LIMIT) begin
                rr = re * re;
                ii = im * im;
                if (rr + ii >= (longint'(4) << (2 * FRAC_BITS))) begin
                    escaped = 1'b1;
                end else begin
                    ri = re * im;
                    re = ((rr - ii) >>> FRAC_BITS) + c_re;
                    im = ((2 * ri) >>> FRAC_BITS) + c_im;
                    updates++;
                end
            end
            updates          = updates + 1;
            res.escape_count = 7'(updates);
            res.blue_byte    = 8'(updates * 2);
            res.green_byte   = 8'(updates * 6);
            res.red_byte     = 8'(updates * 4);
            return res;
        endfunction

        function void note_pixel(t_pixel_in p);
            expected_escapes.push_back(predict_escape(p));
        endfunction

        function int pending();
            return expected_escapes.size();
        endfunction

        function void flag_failure(string what);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("MISMATCH %s", what);
        endfunction

        function void check_escape(t_pixel_out got);
            t_pixel_out want;
            if (expected_escapes.size() == 0) begin
                flag_failure($sformatf("unexpected result: count %0d blue %0d green %0d red %0d",
                    got.escape_count, got.blue_byte, got.green_byte, got.red_byte));
                return;
            end
            want = expected_escapes.pop_front();
            if (got.escape_count !== want.escape_count || got.blue_byte !== want.blue_byte ||
                got.green_byte !== want.green_byte || got.red_byte !== want.red_byte)
                flag_failure($sformatf(
                    "result: expected count %0d blue %0d green %0d red %0d, got %0d %0d %0d %0d",
                    want.escape_count, want.blue_byte, want.green_byte, want.red_byte,
                    got.escape_count, got.blue_byte, got.green_byte, got.red_byte));
        endfunction

        function void check_register(string reg_name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                flag_failure($sformatf("register %s: expected %h, got %h", reg_name, want, got));
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_pixel_in            i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_pixel_out           o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    escape_count_tracker  chk;
    int                   cycle_count  = 0;
    int                   results_seen = 0;
    int                   hold_left    = 0;
    int                   rx_mode      = 0;
    int                   rx_mode_left = 0;
    int                   rx_step      = 0;

    julia_escape_time_pixel_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("julia_escape_time_pixel_core regression: fail");
            $finish;
        end
    end

    // Result side: check each accepted item, then choose the next ready value.
    // The receiver switches between stall patterns of its own and holds off
    // for a long stretch twice so that the pipeline fills and stalls the input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            chk.check_escape(o_out_data);
            results_seen++;
            if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
                hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 300);
                rx_step      = 0;
            end
            rx_mode_left--;
            case (rx_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_out_ready <= ((rx_step % 7) < 3);
                    rx_step++;
                end
            endcase
        end
    end

    // One APB transfer: setup phase, access phase, then the bus goes idle.
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reads both halves of the Julia constant back and compares them.
    task automatic read_back_constant(input logic [15:0] cr, input logic [15:0] ci);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, ADDR_C_REAL, '0, rd);
        chk.check_register("c_real", cr, rd[15:0]);
        apb_access(1'b0, ADDR_C_IMAG, '0, rd);
        chk.check_register("c_imag", ci, rd[15:0]);
    endtask

    // Writes the Julia constant with random upper data bits, which are ignored.
    task automatic set_julia_constant(input logic [15:0] cr, input logic [15:0] ci);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, ADDR_C_REAL, {16'($urandom), cr}, rd);
        apb_access(1'b1, ADDR_C_IMAG, {16'($urandom), ci}, rd);
        chk.set_constant(cr, ci);
        read_back_constant(cr, ci);
    endtask

    // Offers one pixel and waits for its acceptance. Valid is left high.
    task automatic send_pixel(input t_pixel_in p);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        chk.note_pixel(p);
    endtask

    task automatic wait_for_drain();
        while (chk.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mostly anywhere in the frame, often near the centre where the orbits run long.
    function automatic t_pixel_in random_pixel();
        t_pixel_in p;
        if ($urandom_range(0, 9) < 6) begin
            p.pixel_row = 9'($urandom_range(0, 511));
            p.pixel_col = 9'($urandom_range(0, 511));
        end else begin
            p.pixel_row = 9'($urandom_range(160, 352));
            p.pixel_col = 9'($urandom_range(160, 352));
        end
        return p;
    endfunction

    // Corners, the centre, bounded and escaping start points and alternating bits.
    task automatic stream_directed();
        int        rows[14] = '{0, 511, 0, 511, 256, 256, 384, 1, 510, 128, 255, 341, 170, 256};
        int        cols[14] = '{0, 511, 511, 0, 256, 384, 256, 1, 510, 128, 257, 170, 341, 0};
        t_pixel_in p;
        for (int k = 0; k < 14; k++) begin
            p.pixel_row = 9'(rows[k]);
            p.pixel_col = 9'(cols[k]);
            send_pixel(p);
        end
    endtask

    // Random pixels in bursts of random length with random gaps between them.
    task automatic stream_random(input int n_items);
        int left;
        int burst;
        int gap;
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left)
                burst = left;
            repeat (burst) begin
                send_pixel(random_pixel());
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0 && left > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // Phases: reset constant, both extremes, a classic constant, values outside
    // the stated range, a random constant and finally c = 0.
    initial begin
        logic [15:0] phase_cr[N_PHASES];
        logic [15:0] phase_ci[N_PHASES];
        phase_cr = '{C_REAL_RESET, 16'hC000, 16'h4000, 16'hCCCD, 16'h7FFF, 16'h0000, 16'h0000};
        phase_ci = '{C_IMAG_RESET, 16'hC000, 16'h4000, 16'h09FC, 16'h8000, 16'h0000, 16'h0000};
        phase_cr[5] = 16'($urandom_range(0, 65535));
        phase_ci[5] = 16'($urandom_range(0, 65535));

        chk = new();
        chk.set_constant(C_REAL_RESET, C_IMAG_RESET);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back_constant(C_REAL_RESET, C_IMAG_RESET);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                // The sender pauses here until every result of the last phase is in.
                wait_for_drain();
                repeat (10) @(posedge i_clk);
                set_julia_constant(phase_cr[ph], phase_ci[ph]);
            end
            if (ph == 0)
                stream_directed();
            stream_random(RAND_PER_PHASE);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk.pending() != 0)
            chk.flag_failure($sformatf("%0d results never arrived", chk.pending()));
        if (chk.failures == 0) begin
            $display("julia_escape_time_pixel_core regression: pass");
        end else begin
            $display("julia_escape_time_pixel_core regression: fail");
        end
        $finish;
    end

endmodule
